/* rtl/eti_pkg.sv */
package eti_pkg;

   typedef logic        [13:0] power_type;
   typedef logic        [14:0] alt_type;
   typedef logic        [8:0]  mach_type;
   typedef logic signed [20:0] thrust_type;
   typedef logic signed [15:0] tab_type;
   typedef logic        [2:0]  idx_type;

   localparam int HALF_POWER = 50 * 100;
   localparam int ALT_STEP   = 1000;
   localparam int MACH_SCALE = 100;
   localparam int MACH_MUL   = 5;
   localparam int TOP_INDEX  = 4;
   localparam int GRID       = 6;
   localparam int OUT_DIV    = 10;
   localparam int THRUST_MAX = 1048575;
   localparam int THRUST_MIN = -1048576;

   // register stages inside one constant divider
   localparam int DIV_LAT = 4;

   // rows: Mach 0.0 .. 1.0, columns: altitude 0 .. 50000 ft
   localparam tab_type IDLE_TAB [GRID][GRID] = '{
      '{ 16'sd1060,   16'sd670,   16'sd880,   16'sd1140,  16'sd1500,  16'sd1860 },
      '{ 16'sd635,    16'sd425,   16'sd690,   16'sd1010,  16'sd1330,  16'sd1700 },
      '{ 16'sd60,     16'sd25,    16'sd345,   16'sd755,   16'sd1130,  16'sd1525 },
      '{ -16'sd1020,  -16'sd710,  -16'sd300,  16'sd350,   16'sd910,   16'sd1360 },
      '{ -16'sd2700,  -16'sd1900, -16'sd1300, -16'sd247,  16'sd600,   16'sd1100 },
      '{ -16'sd3600,  -16'sd1400, -16'sd595,  -16'sd342,  -16'sd200,  16'sd700  }
   };

   localparam tab_type MIL_TAB [GRID][GRID] = '{
      '{ 16'sd12680, 16'sd9150,  16'sd6200, 16'sd3950, 16'sd2450, 16'sd1400 },
      '{ 16'sd12680, 16'sd9150,  16'sd6313, 16'sd4040, 16'sd2470, 16'sd1400 },
      '{ 16'sd12610, 16'sd9312,  16'sd6610, 16'sd4290, 16'sd2600, 16'sd1560 },
      '{ 16'sd12640, 16'sd9839,  16'sd7090, 16'sd4660, 16'sd2840, 16'sd1660 },
      '{ 16'sd12390, 16'sd10176, 16'sd7750, 16'sd5320, 16'sd3250, 16'sd1930 },
      '{ 16'sd11680, 16'sd9848,  16'sd8050, 16'sd6100, 16'sd3800, 16'sd2310 }
   };

   localparam tab_type AB_TAB [GRID][GRID] = '{
      '{ 16'sd20000, 16'sd15000, 16'sd10800, 16'sd7000,  16'sd4000, 16'sd2500 },
      '{ 16'sd21420, 16'sd15700, 16'sd11225, 16'sd7323,  16'sd4435, 16'sd2600 },
      '{ 16'sd22700, 16'sd16860, 16'sd12250, 16'sd8154,  16'sd5000, 16'sd2835 },
      '{ 16'sd24240, 16'sd18910, 16'sd13760, 16'sd9285,  16'sd5700, 16'sd3215 },
      '{ 16'sd26070, 16'sd21075, 16'sd15975, 16'sd11115, 16'sd6860, 16'sd3950 },
      '{ 16'sd28886, 16'sd23319, 16'sd18300, 16'sd13484, 16'sd8642, 16'sd5057 }
   };

   // count of zero bits below the lowest one bit
   function automatic int trail_zeros(input int d);
      int n;
      n = 0;
      for (int i = 0; i < 31; i++) begin
         if (d[i] == 1'b0 && n == i) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

endpackage

/* rtl/eti_cdiv.sv */
// Signed divide by a constant, truncating toward zero, four register stages.
module eti_cdiv #(
   parameter int WIDTH_IN  = 31,
   parameter int WIDTH_OUT = 21,
   parameter int DIVISOR   = 1000
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [WIDTH_IN-1:0]  in_value,
   output logic signed [WIDTH_OUT-1:0] out_value
);
   import eti_pkg::*;

   // split off the power of two as a shift, then an exact reciprocal for the odd part
   localparam int PRE = trail_zeros(DIVISOR);
   localparam int ODD = DIVISOR >> PRE;
   localparam int K   = WIDTH_IN - PRE;
   localparam int L   = $clog2(ODD);
   localparam int SHR = K + L;
   localparam int MW  = K + 2;
   localparam int HL  = K / 2;
   localparam int PLW = HL + MW;
   localparam int PHW = K - HL + MW;
   localparam int SW  = K + MW;
   localparam int QW  = SW - SHR;
   localparam logic [63:0] RECIP64 = ((64'd1 << SHR) + 64'(ODD) - 64'd1) / 64'(ODD);
   localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

   logic [WIDTH_IN-1:0]         mag;
   logic [K-1:0]                mag_ff;
   logic                        neg1_ff, neg2_ff, neg3_ff;
   logic [PLW-1:0]              pl_in, pl_ff;
   logic [PHW-1:0]              ph_in, ph_ff;
   logic [SW-1:0]               sum_in;
   logic [QW-1:0]               q_ff;
   logic [QW+WIDTH_OUT-1:0]     qx;
   logic signed [WIDTH_OUT-1:0] qt;
   logic signed [WIDTH_OUT-1:0] out_ff;

   assign mag    = in_value[WIDTH_IN-1] ? unsigned'(-in_value) : unsigned'(in_value);
   assign pl_in  = PLW'(mag_ff[HL-1:0]) * PLW'(RECIP);
   assign ph_in  = PHW'(mag_ff[K-1:HL]) * PHW'(RECIP);
   assign sum_in = {ph_ff, {HL{1'b0}}} + SW'(pl_ff);
   assign qx     = {{WIDTH_OUT{1'b0}}, q_ff};
   assign qt     = signed'(qx[WIDTH_OUT-1:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag[WIDTH_IN-1:PRE];
         neg1_ff <= in_value[WIDTH_IN-1];
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         neg2_ff <= neg1_ff;
         q_ff    <= sum_in[SW-1:SHR];
         neg3_ff <= neg2_ff;
         out_ff  <= neg3_ff ? -qt : qt;
      end
   end

   assign out_value = out_ff;

endmodule

/* rtl/engine_thrust_interpolator_top.sv */
// Engine thrust interpolator. Each request beat carries power, altitude and Mach;
// each one yields exactly one response beat with thrust / 10, in request order.
// Idle, military and afterburner thrust come from constant 6x6 grids over Mach
// (step 0.2) and altitude (step 10000 ft); the last grid cell is extrapolated
// beyond the grid. Below half power the result blends idle to military, from half
// power up military to afterburner. All scaling divides truncate toward zero and
// the result saturates to 21 bits signed. The datapath is a 26-stage pipeline plus
// the response register. One beat enters every cycle while the response side
// keeps taking them. The pipeline advances as a whole; it holds only when its last
// stage is full and the response register is full and not being taken, so
// req_ready then follows rsp_ready. There is no kept state and no configuration.
module engine_thrust_interpolator_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  eti_pkg::power_type  req_power_level,
   input  eti_pkg::alt_type    req_altitude_tens_ft,
   input  eti_pkg::mach_type   req_mach_x100,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output eti_pkg::thrust_type rsp_thrust_out
);
   import eti_pkg::*;

   // stages outside the dividers, plus four dividers in series
   localparam int NST   = 10 + 4 * DIV_LAT;
   localparam int OCC_W = $clog2(NST + 2);

   // fields that ride alongside the datapath
   typedef struct packed {
      logic [11:0] dm;
      logic        hi;
      power_type   pwf;
   } side_a_type;

   typedef struct packed {
      logic signed [21:0] lo_m;
      logic signed [21:0] lo_o;
      logic               hi;
      power_type          pwf;
   } side_b_type;

   // ---------------- pipeline control ----------------
   logic [NST-1:0] v_ff;
   logic           rsp_valid_ff;
   logic           out_en;
   logic           pipe_en;
   logic [OCC_W-1:0] occ;

   // the response register loads when empty or being taken; the pipe may also
   // advance when its last stage holds a bubble
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign pipe_en   = out_en || !v_ff[NST-1];
   assign req_ready = pipe_en;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pipe_en) begin
            v_ff <= {v_ff[NST-2:0], req_valid};
         end
         if (out_en) begin
            rsp_valid_ff <= v_ff[NST-1];
         end
      end
   end

   // ---------------- stage 1: grid cell and fractions ----------------
   idx_type     ix_col_in, ix_row_in, ix_col_ff, ix_row_ff;
   tab_type     ix_dh_in, ix_cdh_in, ix_dh_ff, ix_cdh_ff;
   logic [11:0] mach5;
   side_a_type  ix_side_in, ix_side_ff;

   always_comb begin
      ix_col_in = '0;
      ix_row_in = '0;
      mach5     = 12'(req_mach_x100) * 12'(MACH_MUL);
      // clamp the index at the last cell: past it, extrapolate
      for (int i = 1; i <= TOP_INDEX; i++) begin
         if (req_altitude_tens_ft >= 15'(i * ALT_STEP)) begin
            ix_col_in = idx_type'(i);
         end
         if (mach5 >= 12'(i * MACH_SCALE)) begin
            ix_row_in = idx_type'(i);
         end
      end
      ix_dh_in  = signed'({1'b0, req_altitude_tens_ft} - 16'(ix_col_in) * 16'(ALT_STEP));
      ix_cdh_in = tab_type'(ALT_STEP) - ix_dh_in;
      ix_side_in.dm  = mach5 - 12'(ix_row_in) * 12'(MACH_SCALE);
      ix_side_in.hi  = req_power_level >= 14'(HALF_POWER);
      ix_side_in.pwf = ix_side_in.hi ? req_power_level - 14'(HALF_POWER) : req_power_level;
   end

   // ---------------- stage 2: corner lookups ----------------
   // 0..3 military corners, 4..7 idle or afterburner corners;
   // corner order: (r,c) (r,c+1) (r+1,c) (r+1,c+1)
   tab_type    tab_in [8];
   tab_type    tab_ff [8];
   tab_type    tab_dh_ff, tab_cdh_ff;
   side_a_type tab_side_ff;
   idx_type    r1, c1;

   always_comb begin
      r1 = ix_row_ff + 3'd1;
      c1 = ix_col_ff + 3'd1;
      tab_in[0] = MIL_TAB[ix_row_ff][ix_col_ff];
      tab_in[1] = MIL_TAB[ix_row_ff][c1];
      tab_in[2] = MIL_TAB[r1][ix_col_ff];
      tab_in[3] = MIL_TAB[r1][c1];
      tab_in[4] = ix_side_ff.hi ? AB_TAB[ix_row_ff][ix_col_ff] : IDLE_TAB[ix_row_ff][ix_col_ff];
      tab_in[5] = ix_side_ff.hi ? AB_TAB[ix_row_ff][c1]        : IDLE_TAB[ix_row_ff][c1];
      tab_in[6] = ix_side_ff.hi ? AB_TAB[r1][ix_col_ff]        : IDLE_TAB[r1][ix_col_ff];
      tab_in[7] = ix_side_ff.hi ? AB_TAB[r1][c1]               : IDLE_TAB[r1][c1];
   end

   // ---------------- stage 3: altitude weights ----------------
   logic signed [30:0] prd_in [8];
   logic signed [30:0] prd_ff [8];
   side_a_type         prd_side_ff;

   for (genvar g = 0; g < 8; g++) begin : g_prd
      // left column weighs by the remaining step, right column by the fraction
      assign prd_in[g] = 31'(tab_ff[g]) * 31'((g % 2 == 1) ? tab_dh_ff : tab_cdh_ff);
   end

   // ---------------- divide by the altitude step ----------------
   logic signed [20:0] qa [8];
   side_a_type         da_side_ff [DIV_LAT];

   for (genvar g = 0; g < 8; g++) begin : g_diva
      eti_cdiv #(.WIDTH_IN(31), .WIDTH_OUT(21), .DIVISOR(ALT_STEP)) u_div (
         .clock     (clock),
         .en        (pipe_en),
         .in_value  (prd_ff[g]),
         .out_value (qa[g])
      );
   end

   // ---------------- stage: row sums ----------------
   // 0 military low row, 1 military high row, 2 other low row, 3 other high row
   logic signed [21:0] sum_in [4];
   logic signed [21:0] sum_ff [4];
   side_a_type         sum_side_ff;

   for (genvar g = 0; g < 4; g++) begin : g_sum
      assign sum_in[g] = 22'(qa[2*g]) + 22'(qa[2*g+1]);
   end

   // ---------------- stage: row differences ----------------
   logic signed [22:0] dif_m_ff, dif_o_ff;
   logic signed [21:0] dif_lo_m_ff, dif_lo_o_ff;
   side_a_type         dif_side_ff;

   // ---------------- stage: Mach weight ----------------
   logic signed [33:0] mul_m_ff, mul_o_ff;
   side_b_type         mul_side_in, mul_side_ff;

   always_comb begin
      mul_side_in.lo_m = dif_lo_m_ff;
      mul_side_in.lo_o = dif_lo_o_ff;
      mul_side_in.hi   = dif_side_ff.hi;
      mul_side_in.pwf  = dif_side_ff.pwf;
   end

   // ---------------- divide by the Mach scale ----------------
   logic signed [27:0] qm_m, qm_o;
   side_b_type         db_side_ff [DIV_LAT];

   eti_cdiv #(.WIDTH_IN(34), .WIDTH_OUT(28), .DIVISOR(MACH_SCALE)) u_div_mil (
      .clock     (clock),
      .en        (pipe_en),
      .in_value  (mul_m_ff),
      .out_value (qm_m)
   );

   eti_cdiv #(.WIDTH_IN(34), .WIDTH_OUT(28), .DIVISOR(MACH_SCALE)) u_div_oth (
      .clock     (clock),
      .en        (pipe_en),
      .in_value  (mul_o_ff),
      .out_value (qm_o)
   );

   // ---------------- stage: interpolated table values ----------------
   logic signed [27:0] lkp_m_ff, lkp_o_ff;
   logic               lkp_hi_ff;
   power_type          lkp_pwf_ff;

   // ---------------- stage: blend base and span ----------------
   logic signed [27:0] bld_base_ff;
   logic signed [28:0] bld_span_ff;
   power_type          bld_pwf_ff;

   // ---------------- stage: power weight ----------------
   logic signed [41:0] bpr_ff;
   logic signed [27:0] bpr_base_ff;

   // ---------------- divide by half power ----------------
   logic signed [29:0] qp;
   logic signed [27:0] dc_base_ff [DIV_LAT];

   eti_cdiv #(.WIDTH_IN(42), .WIDTH_OUT(30), .DIVISOR(HALF_POWER)) u_div_pwr (
      .clock     (clock),
      .en        (pipe_en),
      .in_value  (bpr_ff),
      .out_value (qp)
   );

   // ---------------- stage: total ----------------
   logic signed [29:0] tot_ff;

   // ---------------- final scale and saturate ----------------
   logic signed [26:0] qo;
   thrust_type         rsp_thrust_in, rsp_thrust_ff;

   eti_cdiv #(.WIDTH_IN(30), .WIDTH_OUT(27), .DIVISOR(OUT_DIV)) u_div_out (
      .clock     (clock),
      .en        (pipe_en),
      .in_value  (tot_ff),
      .out_value (qo)
   );

   always_comb begin
      if (qo > 27'(THRUST_MAX)) begin
         rsp_thrust_in = thrust_type'(THRUST_MAX);
      end else if (qo < 27'(THRUST_MIN)) begin
         rsp_thrust_in = thrust_type'(THRUST_MIN);
      end else begin
         rsp_thrust_in = qo[20:0];
      end
   end

   // ---------------- datapath registers, no reset ----------------
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ix_col_ff  <= ix_col_in;
         ix_row_ff  <= ix_row_in;
         ix_dh_ff   <= ix_dh_in;
         ix_cdh_ff  <= ix_cdh_in;
         ix_side_ff <= ix_side_in;

         tab_ff      <= tab_in;
         tab_dh_ff   <= ix_dh_ff;
         tab_cdh_ff  <= ix_cdh_ff;
         tab_side_ff <= ix_side_ff;

         prd_ff      <= prd_in;
         prd_side_ff <= tab_side_ff;

         // advance the side fields in step with the dividers
         da_side_ff[0] <= prd_side_ff;
         db_side_ff[0] <= mul_side_ff;
         dc_base_ff[0] <= bpr_base_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            da_side_ff[i] <= da_side_ff[i-1];
            db_side_ff[i] <= db_side_ff[i-1];
            dc_base_ff[i] <= dc_base_ff[i-1];
         end

         sum_ff      <= sum_in;
         sum_side_ff <= da_side_ff[DIV_LAT-1];

         dif_m_ff    <= 23'(sum_ff[1]) - 23'(sum_ff[0]);
         dif_o_ff    <= 23'(sum_ff[3]) - 23'(sum_ff[2]);
         dif_lo_m_ff <= sum_ff[0];
         dif_lo_o_ff <= sum_ff[2];
         dif_side_ff <= sum_side_ff;

         mul_m_ff    <= 34'(dif_m_ff) * 34'(signed'({1'b0, dif_side_ff.dm}));
         mul_o_ff    <= 34'(dif_o_ff) * 34'(signed'({1'b0, dif_side_ff.dm}));
         mul_side_ff <= mul_side_in;

         lkp_m_ff   <= 28'(db_side_ff[DIV_LAT-1].lo_m) + qm_m;
         lkp_o_ff   <= 28'(db_side_ff[DIV_LAT-1].lo_o) + qm_o;
         lkp_hi_ff  <= db_side_ff[DIV_LAT-1].hi;
         lkp_pwf_ff <= db_side_ff[DIV_LAT-1].pwf;

         // low power: idle toward military; high power: military toward afterburner
         bld_base_ff <= lkp_hi_ff ? lkp_m_ff : lkp_o_ff;
         bld_span_ff <= lkp_hi_ff ? 29'(lkp_o_ff) - 29'(lkp_m_ff)
                                  : 29'(lkp_m_ff) - 29'(lkp_o_ff);
         bld_pwf_ff  <= lkp_pwf_ff;

         bpr_ff      <= 42'(bld_span_ff) * 42'(signed'({1'b0, bld_pwf_ff}));
         bpr_base_ff <= bld_base_ff;

         tot_ff <= 30'(dc_base_ff[DIV_LAT-1]) + qp;
      end
      if (out_en) begin
         rsp_thrust_ff <= rsp_thrust_in;
      end
   end

   assign rsp_thrust_out = rsp_thrust_ff;

   // ---------------- assertions ----------------
   assign occ = OCC_W'($countones({v_ff, rsp_valid_ff}));

   // an empty response register never blocks the request side
   a_ready_when_out_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("req_ready low while response register empty");

   // a beat taken in with none delivered adds exactly one to the beats in flight
   a_occ_grow : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready)) |=> occ == $past(occ) + 1'b1)
      else $error("accepted beat lost or duplicated in pipeline");

   // a beat delivered with none taken in removes exactly one
   a_occ_shrink : assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && rsp_valid && rsp_ready) |=> occ == $past(occ) - 1'b1)
      else $error("delivered beat not retired from pipeline");

   // the beats in flight do not change without a handshake on either side
   a_occ_hold : assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && !(rsp_valid && rsp_ready)) |=> occ == $past(occ))
      else $error("beat count changed without a handshake");

endmodule
